[src/assert_macros.svh]
// Assertion macros used by the repacker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[src/repk_pkg.sv]
// Package with the types and constants of the 7/8-bit repacker.
`timescale 1ns / 1ps
package repk_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int GROUP_BITS  = 7;
  localparam int CNT_BITS    = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // One or two result bytes produced by one input item.
  typedef struct packed {
    logic                 two;
    logic [BYTE_BITS-1:0] b0;
    logic [BYTE_BITS-1:0] b1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[src/repk_in_if.sv]
// Input channel interface: one byte and its end-of-buffer flag per item.
`timescale 1ns / 1ps
interface repk_in_if;
  import repk_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_in;
  logic                 end_of_buffer;

  modport source (output valid, output data_in, output end_of_buffer, input ready);
  modport sink (input valid, input data_in, input end_of_buffer, output ready);
endinterface

[src/repk_out_if.sv]
// Output channel interface: one result byte and its run-last flag per item.
`timescale 1ns / 1ps
interface repk_out_if;
  import repk_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_out;
  logic                 run_last;

  modport source (output valid, output data_out, output run_last, input ready);
  modport sink (input valid, input data_out, input run_last, output ready);
endinterface

[src/base128_bit_repacker_top.sv]
// Top level of the 7-bit / 8-bit repacker: front end, job queue and sequencer.
`timescale 1ns / 1ps
// Usage: bytes enter on the in_i channel (data_in, end_of_buffer) with a
// valid/ready handshake and results leave on out_o (data_out, run_last).
// cfg_we_i/cfg_wdata_i write the mode register (0 packs bytes into 7-bit
// groups, 1 unpacks 7-bit groups into bytes); a write also clears the bits
// that are still pending. Write it only while the block is idle.
// An accepted item is turned into its results in the same cycle and written
// into a two-entry job queue; the sequencer then moves its first result from
// the queue into the output register, and one result leaves per cycle while
// the receiver takes them.
// Throughput is one item per cycle while the output keeps up and the queue
// has room; an item with two results holds the sequencer for both, so a long
// pack run or flushes with pending bits can fill the queue and stall the input.
// Items that cause no result (unpacking the first group of a run) pass
// through the front end without using the queue.
// When the receiver stalls, the output register holds its item, the queue
// fills, and in_i.ready drops only once both queue entries are taken.
// Reset selects pack mode, empties the accumulator, the queue and the
// output register; there is no clearing pass.
`include "assert_macros.svh"
module base128_bit_repacker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  repk_in_if.sink    in_i,
  repk_out_if.source out_o
);
  import repk_pkg::*;

  logic        push;
  logic        pop;
  job_t        front_job;
  job_t        queue_job;
  queue_stat_t q_stat;

  // Front end classifies each item and keeps the bit accumulator.
  repk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .job_o       (front_job)
  );

  // The queue lets the input keep flowing while a result waits.
  repk_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .job_o  (queue_job),
    .stat_o (q_stat)
  );

  // The sequencer splits two-result jobs and sends their results one after the other.
  repk_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (queue_job),
    .q_empty_i (q_stat.empty),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  // A job is never offered to a full queue.
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && q_stat.full)
  // The queue cannot be full and empty at once.
  `ASSERT_NEVER(a_stat_sane, clk_i, rst_ni, q_stat.full && q_stat.empty)
  // The first result of a pair is followed at once by its closing result.
  `ASSERT_PROP(a_pair_next, clk_i, rst_ni,
    (out_o.valid && out_o.ready && !out_o.run_last) |=> (out_o.valid && out_o.run_last))

endmodule

[src/repk_front.sv]
// Front end: accepts items, keeps the pending bits and forms result jobs.
`timescale 1ns / 1ps
module repk_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  repk_in_if.sink       in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output repk_pkg::job_t job_o
);
  import repk_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [GROUP_BITS-1:0] pend_q, pend_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;

  logic                  accept;
  logic [CNT_BITS-1:0]   cnt_e;
  logic [CNT_BITS-1:0]   n_new;
  logic [14:0]           acc_e;
  logic [13:0]           acc_d;
  logic [GROUP_BITS-1:0] rem;
  logic [GROUP_BITS-1:0] pad;
  logic                  has_out;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    cnt_e   = (cnt_q > 3'd6) ? '0 : cnt_q;
    acc_e   = {pend_q, in_i.data_in};
    acc_d   = {pend_q, in_i.data_in[GROUP_BITS-1:0]};
    n_new   = '0;
    rem     = '0;
    pad     = '0;
    has_out = 1'b0;
    job_o   = '0;
    unique case (mode_q)
      MODE_ENCODE: begin
        has_out = 1'b1;
        if (cnt_e == 3'd6) begin
          // Fourteen bits on hand: two full groups, nothing left.
          job_o.two = 1'b1;
          job_o.b0  = {1'b0, acc_e[13:7]};
          job_o.b1  = {1'b0, acc_e[6:0]};
        end else begin
          n_new    = 3'(cnt_e + 3'd1);
          job_o.b0 = {1'b0, 7'(acc_e >> n_new)};
          rem      = acc_e[GROUP_BITS-1:0] & ~(7'h7F << n_new);
          pad      = 7'(rem << (3'd7 - n_new));
          if (in_i.end_of_buffer) begin
            job_o.two = 1'b1;
            job_o.b1  = {1'b0, pad};
          end
        end
      end
      MODE_DECODE: begin
        if (cnt_q != '0) begin
          has_out  = 1'b1;
          n_new    = 3'(cnt_q - 3'd1);
          job_o.b0 = 8'(acc_d >> n_new);
          rem      = acc_d[GROUP_BITS-1:0] & ~(7'h7F << n_new);
        end else begin
          n_new = 3'd7;
          rem   = in_i.data_in[GROUP_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  assign push_o = accept && has_out;

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (cfg_we_i) begin
      // A mode write always starts from an empty accumulator.
      mode_d = mode_e'(cfg_wdata_i);
      pend_d = '0;
      cnt_d  = '0;
    end else if (accept) begin
      if (in_i.end_of_buffer) begin
        pend_d = '0;
        cnt_d  = '0;
      end else begin
        pend_d = rem;
        cnt_d  = n_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[src/repk_queue.sv]
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps
module repk_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  repk_pkg::job_t        job_i,
  input  logic                  pop_i,
  output repk_pkg::job_t        job_o,
  output repk_pkg::queue_stat_t stat_o
);
  import repk_pkg::*;

  job_t                 entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign stat_o.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = entry_q[rd_ptr_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : QPTR_BITS'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : QPTR_BITS'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = QCNT_BITS'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCNT_BITS'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[src/repk_back.sv]
// Output sequencer: turns queued jobs into one result item per cycle while the receiver is ready.
`timescale 1ns / 1ps
module repk_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  repk_pkg::job_t job_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  repk_out_if.source     out_o
);
  import repk_pkg::*;

  logic                 out_valid_q, out_valid_d;
  logic [BYTE_BITS-1:0] out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;
  logic                 sec_valid_q, sec_valid_d;
  logic [BYTE_BITS-1:0] sec_data_q, sec_data_d;
  logic                 load_ok;

  assign load_ok        = !out_valid_q || out_o.ready;
  assign pop_o          = load_ok && !sec_valid_q && !q_empty_i;
  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;
  assign out_o.run_last = out_last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    sec_valid_d = sec_valid_q;
    sec_data_d  = sec_data_q;
    if (load_ok) begin
      priority if (sec_valid_q) begin
        // Second result of a pair goes out before any new job.
        out_valid_d = 1'b1;
        out_data_d  = sec_data_q;
        out_last_d  = 1'b1;
        sec_valid_d = 1'b0;
      end else if (!q_empty_i) begin
        out_valid_d = 1'b1;
        out_data_d  = job_i.b0;
        out_last_d  = !job_i.two;
        sec_valid_d = job_i.two;
        sec_data_d  = job_i.b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_valid_q <= sec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    sec_data_q <= sec_data_d;
  end

endmodule
